### sv/lkxc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lcg keystream xor cipher core
// no dependencies

package lkxc_pkg;

	localparam int POS_W  = 32;
	localparam int HALF_W = POS_W - 1;
	localparam int LCG_W  = 31;
	localparam int PROD_W = 2 * LCG_W;

	localparam logic [LCG_W-1:0] LCG_MOD   = 31'h7FFFFFFF;
	localparam logic [LCG_W-1:0] LCG_MUL   = 31'h000041A7;
	localparam logic [LCG_W-1:0] INIT_KEY0 = 31'h00000001;

	typedef struct packed {
		logic        command;
		logic [7:0]  data_byte;
		logic [31:0] seek_offset;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [31:0] result_position;
		logic        seek_done;
	} result_t;

	typedef enum logic [1:0] {
		OP_STEP,
		OP_MULT,
		OP_SQR,
		OP_FINAL
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_BIT,
		ST_MUL,
		ST_RED,
		ST_OUT
	} fsm_t;

	typedef struct packed {
		logic accept;
		logic mul_go;
		logic red_go;
		logic seek_wr;
		op_t  op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cmd_seek;
		logic pos_odd;
		logic fixed;
		logic n_zero;
		logic n_lsb;
		logic out_free;
	} dp_status_t;

endpackage

### sv/lcg_keystream_xor_cipher_core.sv
`timescale 1ns / 1ps
// top level of the lcg keystream xor cipher core
// depends on lkxc_pkg, lkxc_ctrl, lkxc_datapath
//
// channel   signals                              transfer when
// item      item_valid, item_stall, item         item_valid && !item_stall
// result    result_valid, result_stall, result   result_valid && !result_stall
// cfg       cfg_valid, cfg_ready, cfg_data       cfg_valid && cfg_ready
//
// data byte at even position: output only; at odd position: output plus one lcg step
// through the shared multiply / mod 2^31-1 reduce unit (multiply, then reduce).
// seek: square-and-multiply jump-ahead on the same unit, one multiply and reduce per
// bit of the step count (two for a set bit) and a final one; no jump with no step.
// reset: init key 1, position 0; items and seek results are held off while the
// result register holds a stalled result.

module lcg_keystream_xor_cipher_core import lkxc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LCG_W-1:0] cfg_data,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	lkxc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	lkxc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### sv/lkxc_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the cipher core: item acceptance, lcg step and seek jump-ahead
// depends on lkxc_pkg

module lkxc_ctrl import lkxc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	fsm_t state_q, state_d;
	op_t  op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_STEP;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		cmd         = '0;
		cmd.op      = op_q;
		item_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = !status.out_free;
				if (item_valid && status.out_free) begin
					cmd.accept = 1'b1;
					if (status.cmd_seek) begin
						state_d = ST_CHK;
					end else if (status.pos_odd && !status.fixed) begin
						op_d    = OP_STEP;
						state_d = ST_MUL;
					end
				end
			end
			ST_CHK: begin
				if (status.n_zero || status.fixed) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_BIT;
				end
			end
			ST_BIT: begin
				if (status.n_zero) begin
					op_d = OP_FINAL;
				end else if (status.n_lsb) begin
					op_d = OP_MULT;
				end else begin
					op_d = OP_SQR;
				end
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_go = 1'b1;
				state_d    = ST_RED;
			end
			ST_RED: begin
				cmd.red_go = 1'b1;
				case (op_q)
					OP_STEP:  state_d = ST_IDLE;
					OP_MULT: begin
						op_d    = OP_SQR;
						state_d = ST_MUL;
					end
					OP_SQR:   state_d = ST_BIT;
					OP_FINAL: state_d = ST_OUT;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.seek_wr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### sv/lkxc_datapath.sv
`timescale 1ns / 1ps
// cipher datapath: lcg state, position, shared mod 2^31-1 multiplier, result register
// depends on lkxc_pkg

module lkxc_datapath import lkxc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LCG_W-1:0] cfg_data,
	input  item_t            item,
	input  ctrl_cmd_t        cmd,
	output dp_status_t       status,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	logic [LCG_W-1:0]  init_key_q, state_q, mult_q, base_q;
	logic [POS_W-1:0]  pos_q;
	logic [HALF_W-1:0] n_q;
	logic [PROD_W-1:0] prod_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [7:0]        key_lo, key_hi;
	logic [POS_W-1:0]  target;
	logic [HALF_W-1:0] n_fwd;
	logic              seek_back, seek_fwd;
	logic [LCG_W-1:0]  opa, opb;
	logic [LCG_W:0]    red_sum, red_sub;
	logic [LCG_W-1:0]  red_res;
	logic              out_free, take;

	assign key_lo = state_q[30:23];
	assign key_hi = state_q[22:15];

	assign target    = POS_W'(item.seek_offset);
	assign seek_fwd  = target > pos_q;
	assign seek_back = target < pos_q;
	assign n_fwd     = target[POS_W-1:1] - pos_q[POS_W-1:1];

	always_comb begin
		case (cmd.op)
			OP_STEP: begin
				opa = state_q;
				opb = LCG_MUL;
			end
			OP_MULT: begin
				opa = mult_q;
				opb = base_q;
			end
			OP_SQR: begin
				opa = base_q;
				opb = base_q;
			end
			OP_FINAL: begin
				opa = state_q;
				opb = mult_q;
			end
			default: begin
				opa = state_q;
				opb = mult_q;
			end
		endcase
	end

	// fold high half onto low half, then one conditional subtract
	assign red_sum = {1'b0, prod_q[PROD_W-1:LCG_W]} + {1'b0, prod_q[LCG_W-1:0]};
	assign red_sub = red_sum - {1'b0, LCG_MOD};
	assign red_res = (red_sum >= {1'b0, LCG_MOD}) ? red_sub[LCG_W-1:0] : red_sum[LCG_W-1:0];

	assign take     = out_valid_q && !result_stall;
	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_key_q  <= INIT_KEY0;
			state_q     <= INIT_KEY0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				init_key_q <= cfg_data;
				state_q    <= cfg_data;
				pos_q      <= '0;
			end else if (cmd.accept) begin
				if (item.command) begin
					pos_q <= target;
					if (seek_back) begin
						state_q <= init_key_q;
					end
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end else if (cmd.red_go && (cmd.op == OP_STEP || cmd.op == OP_FINAL)) begin
				state_q <= red_res;
			end
			if ((cmd.accept && !item.command) || cmd.seek_wr) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && item.command) begin
			mult_q <= 31'd1;
			base_q <= LCG_MUL;
			if (seek_back) begin
				n_q <= target[POS_W-1:1];
			end else if (seek_fwd) begin
				n_q <= n_fwd;
			end else begin
				n_q <= '0;
			end
		end
		if (cmd.mul_go) begin
			prod_q <= PROD_W'(opa) * PROD_W'(opb);
		end
		if (cmd.red_go && cmd.op == OP_MULT) begin
			mult_q <= red_res;
		end
		if (cmd.red_go && cmd.op == OP_SQR) begin
			base_q <= red_res;
			n_q    <= n_q >> 1;
		end
		if (cmd.accept && !item.command) begin
			out_q.out_byte        <= item.data_byte ^ (pos_q[0] ? key_hi : key_lo);
			out_q.result_position <= 32'(pos_q);
			out_q.seek_done       <= 1'b0;
		end else if (cmd.seek_wr) begin
			out_q.out_byte        <= 8'd0;
			out_q.result_position <= 32'(pos_q);
			out_q.seek_done       <= 1'b1;
		end
	end

	assign status.cmd_seek = item.command;
	assign status.pos_odd  = pos_q[0];
	assign status.fixed    = (state_q == '0) || (state_q == LCG_MOD);
	assign status.n_zero   = (n_q == '0);
	assign status.n_lsb    = n_q[0];
	assign status.out_free = out_free;

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
